/* hw/rtl/fpaf_pkg.sv */
package fpaf_pkg;

  localparam int RawW  = 32;
  localparam int ValW  = 18;
  localparam int NumW  = 17;
  localparam int DigW  = 4;
  localparam int CharW = 8;
  localparam int NumChars = 6;
  localparam int DataW = NumChars * CharW;
  localparam int NumSplits = 4;
  localparam int ProdW = 25;
  localparam int BinShift = 8;

  localparam logic [RawW-1:0]  DecMax   = 32'd9999;
  localparam logic [RawW-1:0]  BinMax   = 32'd255999;
  localparam logic [6:0]       BinScale = 7'd100;

  localparam logic [NumW-1:0] Weight10000 = 17'd10000;
  localparam logic [NumW-1:0] Weight1000  = 17'd1000;
  localparam logic [NumW-1:0] Weight100   = 17'd100;
  localparam logic [NumW-1:0] Weight10    = 17'd10;

  localparam logic [CharW-1:0] CharSpace = 8'h20;
  localparam logic [CharW-1:0] CharStar  = 8'h2A;
  localparam logic [CharW-1:0] CharMinus = 8'h2D;
  localparam logic [CharW-1:0] CharDot   = 8'h2E;
  localparam logic [CharW-1:0] CharZero  = 8'h30;

  typedef enum logic {
    ModeDecimal = 1'b0,
    ModeBinary  = 1'b1
  } fpaf_mode_t;

  typedef struct packed {
    fpaf_mode_t mode;
    logic       neg;
    logic       oor;
  } fpaf_ctl_t;

  typedef struct packed {
    fpaf_ctl_t                       ctl;
    logic [NumW-1:0]                 num;
    logic [NumSplits-1:0][DigW-1:0]  digits;
  } fpaf_item_t;

  typedef struct packed {
    logic [DigW-1:0] digit;
    logic [NumW-1:0] rem;
  } fpaf_split_t;

  function automatic fpaf_split_t split_digit(input logic [NumW-1:0] num,
                                              input logic [NumW-1:0] weight);
    fpaf_split_t res;
    res.digit = '0;
    for (int k = 1; k <= 9; k++) begin
      if (num >= NumW'(k) * weight) begin
        res.digit = DigW'(k);
      end
    end
    res.rem = num - NumW'(res.digit) * weight;
    return res;
  endfunction

  function automatic logic [CharW-1:0] digit_char(input logic [DigW-1:0] d);
    return CharZero | {{(CharW-DigW){1'b0}}, d};
  endfunction

endpackage

/* hw/rtl/fixed_point_to_ascii_formatter_top.sv */
// Formats one 32-bit fixed-point value per item into six ASCII characters.
// The input channel carries the raw value in in_tdata. The result channel
// carries the six characters in out_tdata, leftmost character in the lowest
// byte, and out_tuser is high when the asterisk overflow pattern was sent.
// cfg_wr_data selects the format when cfg_wr_en is high: 0 is a signed count
// of 0.001 units, 1 is an unsigned count of 1/256 units shown with two
// decimals; write it only while no item is in flight.
// The pipeline has seven register stages: input range check, scaling
// multiply, four decimal digit splits and the character output register.
// One item can be accepted in every cycle while out_tready stays high.
// Each stage holds its item until the next stage can take it, so a stalled
// receiver first fills the empty stages and in_tready falls only when all
// seven stages hold items. Nothing is lost or repeated during a stall.
// Synchronous reset empties the pipeline and selects the decimal format;
// in_tready is low while reset is held.
module fixed_point_to_ascii_formatter_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [fpaf_pkg::RawW-1:0]     in_tdata,   // raw_value
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [fpaf_pkg::DataW-1:0]    out_tdata,  // char_0 .. char_5
  output logic                          out_tuser,  // out_of_range
  input  logic                          cfg_wr_en,
  input  logic                          cfg_wr_data // format_mode
);

  fpaf_pkg::fpaf_mode_t mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= fpaf_pkg::ModeDecimal;
    end else if (cfg_wr_en) begin
      mode_r <= fpaf_pkg::fpaf_mode_t'(cfg_wr_data);
    end
  end

  // Stage 1: sign, magnitude and range check.
  logic                         s1_v_r;
  logic                         s1_ready;
  fpaf_pkg::fpaf_ctl_t          s1_ctl_r;
  fpaf_pkg::fpaf_ctl_t          s1_ctl_nxt;
  logic [fpaf_pkg::ValW-1:0]    s1_val_r;
  logic [fpaf_pkg::ValW-1:0]    s1_val_nxt;
  logic [fpaf_pkg::RawW-1:0]    mag;
  logic                         in_fire;

  always_comb begin
    s1_ctl_nxt.mode = mode_r;
    s1_ctl_nxt.neg  = in_tdata[fpaf_pkg::RawW-1] & (mode_r == fpaf_pkg::ModeDecimal);
    mag = s1_ctl_nxt.neg ? (~in_tdata + 32'd1) : in_tdata;
    if (mode_r == fpaf_pkg::ModeBinary) begin
      s1_ctl_nxt.oor = in_tdata > fpaf_pkg::BinMax;
      s1_val_nxt     = in_tdata[fpaf_pkg::ValW-1:0];
    end else begin
      s1_ctl_nxt.oor = mag > fpaf_pkg::DecMax;
      s1_val_nxt     = mag[fpaf_pkg::ValW-1:0];
    end
  end

  // Stage 2: binary values are scaled to hundredths, q = floor(v * 100 / 256).
  logic                         s2_v_r;
  logic                         s2_ready;
  fpaf_pkg::fpaf_item_t         s2_item_r;
  fpaf_pkg::fpaf_item_t         s2_item_nxt;
  logic [fpaf_pkg::ProdW-1:0]   prod;

  always_comb begin
    prod = fpaf_pkg::ProdW'(s1_val_r) * fpaf_pkg::ProdW'(fpaf_pkg::BinScale);
    s2_item_nxt.ctl    = s1_ctl_r;
    s2_item_nxt.digits = '0;
    if (s1_ctl_r.mode == fpaf_pkg::ModeBinary) begin
      s2_item_nxt.num = prod[fpaf_pkg::BinShift +: fpaf_pkg::NumW];
    end else begin
      s2_item_nxt.num = {3'b000, s1_val_r[13:0]};
    end
  end

  // Stages 3 to 6: one decimal digit split off per stage.
  logic                         dv [fpaf_pkg::NumSplits+1];
  logic                         dr [fpaf_pkg::NumSplits+1];
  fpaf_pkg::fpaf_item_t         di [fpaf_pkg::NumSplits+1];
  logic [fpaf_pkg::NumW-1:0]    weights [fpaf_pkg::NumSplits];

  assign weights[0] = fpaf_pkg::Weight10000;
  assign weights[1] = fpaf_pkg::Weight1000;
  assign weights[2] = fpaf_pkg::Weight100;
  assign weights[3] = fpaf_pkg::Weight10;

  assign dv[0] = s2_v_r;
  assign di[0] = s2_item_r;

  for (genvar g = 0; g < fpaf_pkg::NumSplits; g++) begin : g_split
    fpaf_digit_stage u_stage (
      .clk        (clk),
      .rst_n      (rst_n),
      .up_valid   (dv[g]),
      .up_ready   (dr[g]),
      .up_item    (di[g]),
      .weight     (weights[g]),
      .down_valid (dv[g+1]),
      .down_ready (dr[g+1]),
      .down_item  (di[g+1])
    );
  end

  // Stage 7: character output register.
  logic                         out_v_r;
  logic                         out_ready;
  logic [fpaf_pkg::DataW-1:0]   out_data_r;
  logic [fpaf_pkg::DataW-1:0]   out_data_nxt;
  logic                         out_oor_r;
  fpaf_pkg::fpaf_item_t         fin;
  logic [fpaf_pkg::DigW-1:0]    d4;
  logic [fpaf_pkg::DigW-1:0]    d3;
  logic [fpaf_pkg::DigW-1:0]    d2;
  logic [fpaf_pkg::DigW-1:0]    d1;
  logic [fpaf_pkg::DigW-1:0]    d0;
  logic [fpaf_pkg::CharW-1:0]   ch [fpaf_pkg::NumChars];

  always_comb begin
    fin = di[fpaf_pkg::NumSplits];
    d4  = fin.digits[3];
    d3  = fin.digits[2];
    d2  = fin.digits[1];
    d1  = fin.digits[0];
    d0  = fin.num[fpaf_pkg::DigW-1:0];
    if (fin.ctl.mode == fpaf_pkg::ModeBinary) begin
      if (fin.ctl.oor) begin
        ch[0] = fpaf_pkg::CharStar;
        ch[1] = fpaf_pkg::CharStar;
        ch[2] = fpaf_pkg::CharStar;
        ch[3] = fpaf_pkg::CharDot;
        ch[4] = fpaf_pkg::CharStar;
        ch[5] = fpaf_pkg::CharStar;
      end else begin
        ch[0] = (d4 != '0) ? fpaf_pkg::digit_char(d4) : fpaf_pkg::CharSpace;
        ch[1] = (d4 != '0 || d3 != '0) ? fpaf_pkg::digit_char(d3) : fpaf_pkg::CharSpace;
        ch[2] = fpaf_pkg::digit_char(d2);
        ch[3] = fpaf_pkg::CharDot;
        ch[4] = fpaf_pkg::digit_char(d1);
        ch[5] = fpaf_pkg::digit_char(d0);
      end
    end else begin
      if (fin.ctl.oor) begin
        ch[0] = fpaf_pkg::CharSpace;
        ch[1] = fpaf_pkg::CharStar;
        ch[2] = fpaf_pkg::CharDot;
        ch[3] = fpaf_pkg::CharStar;
        ch[4] = fpaf_pkg::CharStar;
        ch[5] = fpaf_pkg::CharStar;
      end else begin
        ch[0] = fin.ctl.neg ? fpaf_pkg::CharMinus : fpaf_pkg::CharSpace;
        ch[1] = fpaf_pkg::digit_char(d3);
        ch[2] = fpaf_pkg::CharDot;
        ch[3] = fpaf_pkg::digit_char(d2);
        ch[4] = fpaf_pkg::digit_char(d1);
        ch[5] = fpaf_pkg::digit_char(d0);
      end
    end
    for (int k = 0; k < fpaf_pkg::NumChars; k++) begin
      out_data_nxt[k*fpaf_pkg::CharW +: fpaf_pkg::CharW] = ch[k];
    end
  end

  // Ready chain: a stage takes a new item when it is empty or is passing on.
  assign out_ready = ~out_v_r | out_tready;
  assign dr[fpaf_pkg::NumSplits] = out_ready;
  assign s2_ready  = ~s2_v_r | dr[0];
  assign s1_ready  = ~s1_v_r | s2_ready;
  assign in_tready = rst_n & s1_ready;
  assign in_fire   = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_r <= in_tvalid;
      end
      if (s2_ready) begin
        s2_v_r <= s1_v_r;
      end
      if (out_ready) begin
        out_v_r <= dv[fpaf_pkg::NumSplits];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ctl_r <= s1_ctl_nxt;
      s1_val_r <= s1_val_nxt;
    end
    if (s2_ready && s1_v_r) begin
      s2_item_r <= s2_item_nxt;
    end
    if (out_ready && dv[fpaf_pkg::NumSplits]) begin
      out_data_r <= out_data_nxt;
      out_oor_r  <= fin.ctl.oor;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_oor_r;

  logic       out_fire;
  logic [6:0] occ;

  assign out_fire = out_tvalid & out_tready;
  assign occ = {s1_v_r, s2_v_r, dv[1], dv[2], dv[3], dv[4], out_v_r};

  a_fill_count : assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !out_fire) |=> $countones(occ) == $past($countones(occ)) + 1)
    else $error("pipeline did not gain the accepted item");

  a_drain_count : assert property (@(posedge clk) disable iff (!rst_n)
    (!in_fire && out_fire) |=> $countones(occ) + 1 == $past($countones(occ)))
    else $error("pipeline did not lose the delivered item");

  a_hold_count : assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire == out_fire) |=> $countones(occ) == $past($countones(occ)))
    else $error("pipeline item count changed without a handshake");

  a_full_stall : assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(occ) < 7) |-> in_tready)
    else $error("input stalled while a stage was empty");

endmodule

/* hw/rtl/fpaf_digit_stage.sv */
module fpaf_digit_stage (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  fpaf_pkg::fpaf_item_t         up_item,
  input  logic [fpaf_pkg::NumW-1:0]    weight,
  output logic                         down_valid,
  input  logic                         down_ready,
  output fpaf_pkg::fpaf_item_t         down_item
);

  logic                  v_r;
  fpaf_pkg::fpaf_item_t  item_r;
  fpaf_pkg::fpaf_item_t  item_nxt;
  fpaf_pkg::fpaf_split_t split;

  always_comb begin
    split           = fpaf_pkg::split_digit(up_item.num, weight);
    item_nxt        = up_item;
    item_nxt.num    = split.rem;
    item_nxt.digits = {up_item.digits[fpaf_pkg::NumSplits-2:0], split.digit};
  end

  assign up_ready   = ~v_r | down_ready;
  assign down_valid = v_r;
  assign down_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule
